[src/srl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_pkg
// Shared types and constants of the shell redirection lexer.
// ----------------------------------------------------------------------------
package srl_pkg;

    // Lexer modes.
    localparam logic [3:0] M_NORMAL   = 4'd0;
    localparam logic [3:0] M_CMD_DQ   = 4'd1;
    localparam logic [3:0] M_CMD_SQ   = 4'd2;
    localparam logic [3:0] M_AFTER_LT = 4'd3;
    localparam logic [3:0] M_AFTER_GT = 4'd4;
    localparam logic [3:0] M_SKIP     = 4'd5;
    localparam logic [3:0] M_TARGET   = 4'd6;
    localparam logic [3:0] M_TGT_SQ   = 4'd7;
    localparam logic [3:0] M_TGT_DQ   = 4'd8;

    // Redirect kinds.
    localparam logic [1:0] K_INPUT   = 2'd0;
    localparam logic [1:0] K_HEREDOC = 2'd1;
    localparam logic [1:0] K_OUTPUT  = 2'd2;
    localparam logic [1:0] K_APPEND  = 2'd3;

    // Characters of interest.
    localparam logic [7:0] CH_DQ = 8'h22;
    localparam logic [7:0] CH_SQ = 8'h27;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_present;
        logic       char_kind;
        logic       target_closed;
        logic [1:0] redirect_kind;
        logic       line_done;
    } t_result;

endpackage

[src/srl_lex_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_lex_core
// Mode register and the per-byte classification logic of the lexer.
// ----------------------------------------------------------------------------
module srl_lex_core import srl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_emit,
    output t_result    o_result
);

    logic [3:0] r_mode, n_mode;
    logic [1:0] r_pkind, n_pkind;
    logic       r_topen, n_topen;

    always_comb begin
        logic [3:0] mode;
        logic [1:0] pk;
        logic       topen;
        logic       dropped;
        logic       dbl;
        logic       present;
        logic       kind;
        logic       closed;
        logic [1:0] rkind;

        mode    = r_mode;
        pk      = r_pkind;
        topen   = r_topen;
        dropped = 1'b0;
        dbl     = 1'b0;
        present = 1'b0;
        kind    = 1'b0;
        closed  = 1'b0;
        rkind   = K_INPUT;

        // Second byte of an operator decides its kind.
        if (mode == M_AFTER_LT || mode == M_AFTER_GT) begin
            if (mode == M_AFTER_LT) begin
                dbl = (i_char == CH_LT);
                pk  = dbl ? K_HEREDOC : K_INPUT;
            end else begin
                dbl = (i_char == CH_GT);
                pk  = dbl ? K_APPEND : K_OUTPUT;
            end
            mode    = M_SKIP;
            dropped = dbl;
        end
        if (!dropped && mode == M_SKIP) begin
            if (i_char == CH_SP) begin
                dropped = 1'b1;
            end else begin
                mode = M_TARGET;
            end
        end

        if (!dropped) begin
            case (mode)
                M_CMD_DQ: begin
                    present = 1'b1;
                    if (i_char == CH_DQ) mode = M_NORMAL;
                end
                M_CMD_SQ: begin
                    present = 1'b1;
                    if (i_char == CH_SQ) mode = M_NORMAL;
                end
                M_TARGET: begin
                    present = 1'b1;
                    rkind   = pk;
                    if (i_char == CH_SP) begin
                        closed = 1'b1;
                        topen  = 1'b0;
                        mode   = M_NORMAL;
                    end else begin
                        kind = 1'b1;
                        if (i_char == CH_SQ) begin
                            mode = M_TGT_SQ;
                        end else if (i_char == CH_DQ) begin
                            mode = M_TGT_DQ;
                        end
                    end
                end
                M_TGT_SQ: begin
                    present = 1'b1;
                    kind    = 1'b1;
                    rkind   = pk;
                    if (i_char == CH_SQ) mode = M_TARGET;
                end
                M_TGT_DQ: begin
                    present = 1'b1;
                    kind    = 1'b1;
                    rkind   = pk;
                    if (i_char == CH_DQ) mode = M_TARGET;
                end
                default: begin
                    // Normal text, and any mode code without a meaning.
                    if (i_char == CH_LT || i_char == CH_GT) begin
                        mode  = (i_char == CH_LT) ? M_AFTER_LT : M_AFTER_GT;
                        pk    = (i_char == CH_LT) ? K_INPUT : K_OUTPUT;
                        topen = 1'b1;
                    end else begin
                        present = 1'b1;
                        if (i_char == CH_DQ) begin
                            mode = M_CMD_DQ;
                        end else if (i_char == CH_SQ) begin
                            mode = M_CMD_SQ;
                        end else begin
                            mode = M_NORMAL;
                        end
                    end
                end
            endcase
        end

        // The end of the line closes any open target, even an empty one.
        if (i_last && topen) begin
            closed = 1'b1;
            rkind  = pk;
        end

        o_emit                 = present || i_last;
        o_result.char_out      = present ? i_char : 8'd0;
        o_result.char_present  = present;
        o_result.char_kind     = present ? kind : 1'b0;
        o_result.target_closed = closed;
        o_result.redirect_kind = rkind;
        o_result.line_done     = i_last;

        if (i_last) begin
            n_mode  = M_NORMAL;
            n_pkind = K_INPUT;
            n_topen = 1'b0;
        end else begin
            n_mode  = mode;
            n_pkind = pk;
            n_topen = topen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_pkind <= K_INPUT;
            r_topen <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_pkind <= n_pkind;
            r_topen <= n_topen;
        end
    end

endmodule

[src/srl_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srl_out_fifo
// Two-entry result buffer that decouples the lexer from a stalling receiver.
// ----------------------------------------------------------------------------
module srl_out_fifo import srl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !i_push)
        else $error("result pushed into a full buffer");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("result buffer count did not grow on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && w_pop) |=> (r_count == $past(r_count) - 2'd1))
        else $error("result buffer count did not shrink on pop");

endmodule

[src/shell_redirect_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_redirect_lexer
// Splits a command line into command bytes and redirection target bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one byte of the command line per transaction,
//   with tlast marking the final byte of a line. The master channel returns
//   at most one result per byte: the byte itself in tdata, and its flags and
//   redirect kind in tuser. Operator bytes and the spaces after an operator
//   give no result, except that the last byte of a line always gives one,
//   flagged with tlast.
//   Each byte is classified in the cycle it is accepted, against a small mode
//   register; the result is registered in the result buffer before it reaches
//   the master side. One byte can be accepted every cycle while the result
//   buffer has room.
//   A two-entry result buffer sits between the lexer and the master port, so
//   the slave side keeps accepting while one result waits; tready drops only
//   when both entries are held by a stalled receiver.
//   Reset clears the mode to normal text and empties the result buffer.
// ----------------------------------------------------------------------------
module shell_redirect_lexer import srl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] char_out
    output logic [4:0] o_m_axis_tuser,   // [0] char_present, [1] char_kind,
                                         // [2] target_closed, [4:3] redirect_kind
    output logic       o_m_axis_tlast
);

    logic    w_accept;
    logic    w_emit;
    t_result w_result;
    t_result w_out;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    srl_lex_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    srl_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept && w_emit),
        .i_data      (w_result),
        .o_ready     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .i_pop_ready (i_m_axis_tready),
        .o_data      (w_out)
    );

    assign o_m_axis_tdata = w_out.char_out;
    assign o_m_axis_tuser = {w_out.redirect_kind, w_out.target_closed,
                             w_out.char_kind, w_out.char_present};
    assign o_m_axis_tlast = w_out.line_done;

endmodule

[test/tb_shell_redirect_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_redirect_lexer
// Self-checking testbench of the shell redirection lexer.
// ----------------------------------------------------------------------------
// Command lines are fed one byte per transaction, with tlast on the final
// byte. Each accepted byte runs through a lexer model kept in the checker
// class, and the results it predicts are matched in order against the master
// side. A short directed set of lines covers every operator, both quote
// styles in command and target text, empty and unclosed targets and the
// extreme byte values. Random lines follow, mostly built from words, quoted
// runs and redirections, with some raw byte noise. The sender idles in bursts
// and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_shell_redirect_lexer import srl_pkg::*;;

    localparam int ITEM_TARGET = 1350;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 16;

    // Holds the lexer model and the queue of predicted results.
    class lexer_checker;
        t_result    expected_lex_q[$];
        logic [3:0] mode;
        logic [1:0] pend_kind;
        logic       tgt_open;
        int         mismatches;
        int         results_seen;
        int         closes_seen;
        int         target_bytes;

        function new();
            restore();
            mismatches   = 0;
            results_seen = 0;
            closes_seen  = 0;
            target_bytes = 0;
        endfunction

        function void restore();
            mode      = M_NORMAL;
            pend_kind = K_INPUT;
            tgt_open  = 1'b0;
        endfunction

        // Advances the model by one accepted byte and queues its result.
        function void note_byte(input logic [7:0] c, input logic last);
            t_result    r;
            logic [3:0] m;
            logic       present;
            logic       kind;
            logic       closed;
            logic       dbl;
            logic       dropped;
            logic [1:0] rk;
            m       = mode;
            present = 1'b0;
            kind    = 1'b0;
            closed  = 1'b0;
            rk      = K_INPUT;
            dropped = 1'b0;

            // The byte after a single operator decides whether it doubles.
            if (m == M_AFTER_LT || m == M_AFTER_GT) begin
                dbl = (c == ((m == M_AFTER_LT) ? CH_LT : CH_GT));
                if (m == M_AFTER_LT) begin
                    pend_kind = dbl ? K_HEREDOC : K_INPUT;
                end else begin
                    pend_kind = dbl ? K_APPEND : K_OUTPUT;
                end
                m = M_SKIP;
                dropped = dbl;
            end
            if (!dropped && m == M_SKIP) begin
                if (c == CH_SP) begin
                    dropped = 1'b1;
                end else begin
                    m = M_TARGET;
                end
            end

            if (!dropped) begin
                case (m)
                    M_CMD_DQ: begin
                        present = 1'b1;
                        if (c == CH_DQ) m = M_NORMAL;
                    end
                    M_CMD_SQ: begin
                        present = 1'b1;
                        if (c == CH_SQ) m = M_NORMAL;
                    end
                    M_TARGET: begin
                        present = 1'b1;
                        rk      = pend_kind;
                        if (c == CH_SP) begin
                            // The closing space passes on as command text.
                            closed   = 1'b1;
                            tgt_open = 1'b0;
                            m        = M_NORMAL;
                        end else begin
                            kind = 1'b1;
                            if (c == CH_SQ) begin
                                m = M_TGT_SQ;
                            end else if (c == CH_DQ) begin
                                m = M_TGT_DQ;
                            end
                        end
                    end
                    M_TGT_SQ, M_TGT_DQ: begin
                        present = 1'b1;
                        kind    = 1'b1;
                        rk      = pend_kind;
                        if (c == ((m == M_TGT_SQ) ? CH_SQ : CH_DQ)) m = M_TARGET;
                    end
                    default: begin
                        if (c == CH_LT || c == CH_GT) begin
                            m         = (c == CH_LT) ? M_AFTER_LT : M_AFTER_GT;
                            pend_kind = (c == CH_LT) ? K_INPUT : K_OUTPUT;
                            tgt_open  = 1'b1;
                        end else begin
                            present = 1'b1;
                            if (c == CH_DQ) begin
                                m = M_CMD_DQ;
                            end else if (c == CH_SQ) begin
                                m = M_CMD_SQ;
                            end else begin
                                m = M_NORMAL;
                            end
                        end
                    end
                endcase
            end

            if (last && tgt_open) begin
                closed = 1'b1;
                rk     = pend_kind;
            end
            mode = m;

            if (present || last) begin
                r.char_out      = present ? c : 8'h00;
                r.char_present  = present;
                r.char_kind     = present ? kind : 1'b0;
                r.target_closed = closed;
                r.redirect_kind = rk;
                r.line_done     = last;
                expected_lex_q.push_back(r);
            end
            if (last) restore();
        endfunction

        function void check_result(input t_result got);
            t_result want;
            results_seen++;
            if (got.target_closed) closes_seen++;
            if (got.char_present && got.char_kind) target_bytes++;
            if (expected_lex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: %0t unexpected result %h", $realtime, got);
                end
                return;
            end
            want = expected_lex_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: %0t result %0d mismatch", $realtime, results_seen);
                    $display("  char_out      exp %h got %h", want.char_out, got.char_out);
                    $display("  char_present  exp %b got %b",
                             want.char_present, got.char_present);
                    $display("  char_kind     exp %b got %b", want.char_kind, got.char_kind);
                    $display("  target_closed exp %b got %b",
                             want.target_closed, got.target_closed);
                    $display("  redirect_kind exp %0d got %0d",
                             want.redirect_kind, got.redirect_kind);
                    $display("  line_done     exp %b got %b", want.line_done, got.line_done);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    lexer_checker sb = new();

    logic [7:0] line_q[$];
    int         bytes_sent;
    int         lines_sent;
    int         burst_left;
    int         idle_cycles;
    int         rx_style;
    int         rx_left;
    int         rx_cycle;

    shell_redirect_lexer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver: switches between random stall styles.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(20, 120);
        end else begin
            rx_left--;
        end
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= rx_cycle[2];
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.char_out      = m_tdata;
            got.char_present  = m_tuser[0];
            got.char_kind     = m_tuser[1];
            got.target_closed = m_tuser[2];
            got.redirect_kind = m_tuser[4:3];
            got.line_done     = m_tlast;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        sb.note_byte(c, last);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        if (line_q.size() == 0) line_q.push_back("a");
        foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
        line_q.delete();
        lines_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
        send_line();
    endtask

    task automatic add_word();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) begin
                line_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                line_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
            end
        end
    endtask

    // A quoted run whose body may hold spaces and operator letters.
    task automatic add_quoted();
        logic [7:0] q;
        int         n;
        int         pick;
        q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        n = $urandom_range(0, 5);
        line_q.push_back(q);
        repeat (n) begin
            pick = $urandom_range(0, 5);
            case (pick)
                0: line_q.push_back(CH_SP);
                1: line_q.push_back(CH_LT);
                2: line_q.push_back(CH_GT);
                3: line_q.push_back((q == CH_SQ) ? CH_DQ : CH_SQ);
                default: line_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
            endcase
        end
        if ($urandom_range(0, 4) != 0) line_q.push_back(q);
    endtask

    task automatic add_redirect();
        logic [7:0] op;
        int         n;
        op = $urandom_range(0, 1) ? CH_LT : CH_GT;
        line_q.push_back(op);
        if ($urandom_range(0, 1)) line_q.push_back(op);
        n = $urandom_range(0, 2);
        repeat (n) line_q.push_back(CH_SP);
        case ($urandom_range(0, 9))
            0: ;
            1, 2: add_quoted();
            3: begin
                add_word();
                add_quoted();
                add_word();
            end
            default: add_word();
        endcase
    endtask

    task automatic build_line();
        int n;
        int tok;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            tok = $urandom_range(0, 9);
            case (tok)
                0, 1, 2, 3: add_word();
                4: add_quoted();
                5, 6, 7: add_redirect();
                8: line_q.push_back(CH_SP);
                default: line_q.push_back(8'($urandom_range(0, 255)));
            endcase
            if (i != n - 1 && $urandom_range(0, 3) != 0) line_q.push_back(CH_SP);
        end
        if ($urandom_range(0, 5) == 0) line_q.push_back(CH_SP);
    endtask

    task automatic build_noise();
        int n;
        n = $urandom_range(1, 10);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1: line_q.push_back(CH_SP);
                2: line_q.push_back(CH_SQ);
                3: line_q.push_back(CH_DQ);
                4: line_q.push_back(CH_LT);
                5: line_q.push_back(CH_GT);
                default: line_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        bytes_sent  = 0;
        lines_sent  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        rx_style    = 0;
        rx_left     = 0;
        rx_cycle    = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Heredoc with a skipped space, framed by the extreme byte values.
        line_q = '{8'h00, CH_LT, CH_LT, CH_SP, 8'h68, 8'hff};
        send_line();
        send_text(">>'a b' c");     // append, quoted space in target, closing space
        send_text("<>\"q");         // input target starting with '>', unclosed quote
        send_text("\"<\"'>");       // operators inside command quotes, unclosed
        send_text(">");             // empty target on a single byte line
        send_text("a> ");           // line ends on a dropped space

        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0) begin
                build_noise();
            end else begin
                build_line();
            end
            send_line();
        end
        s_tvalid <= 1'b0;

        while (sb.expected_lex_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d lines with %0d bytes; checked %0d results.",
                 lines_sent, bytes_sent, sb.results_seen);
        $display("Saw %0d target bytes and %0d target closes; %0d mismatches, %0d left over.",
                 sb.target_bytes, sb.closes_seen, sb.mismatches, sb.expected_lex_q.size());
        if (sb.mismatches == 0 && sb.expected_lex_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
src/srl_pkg.sv
src/srl_lex_core.sv
src/srl_out_fifo.sv
src/shell_redirect_lexer.sv
test/tb_shell_redirect_lexer.sv
